/* rtl/core/fcpa_pkg.sv */
// Shared widths, codes, types and reset values of the chunk pool allocator.
package fcpa_pkg;

    localparam int MAX_CHUNKS_DEF = 64;

    localparam int ADDR_W    = 32;
    localparam int BYTES_W   = 16;
    localparam int COUNT_W   = 7;
    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;
    // chunk offset inside the pool never exceeds 65535 * 126
    localparam int OFF_W     = BYTES_W + COUNT_W;
    // chunk index inside the pool fits in seven bits
    localparam int QUO_W     = COUNT_W;

    localparam logic [ACTION_W-1:0] ACT_GET    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PUT    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REFILL = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_START = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT = 2'd2;

    localparam logic [ADDR_W-1:0]  POOL_BASE_RST   = 32'd0;
    localparam logic [BYTES_W-1:0] CHUNK_BYTES_RST = 16'd64;
    localparam logic [COUNT_W-1:0] CHUNK_COUNT_RST = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET_WAIT,
        S_PUT_PREP,
        S_PUT_RANGE,
        S_PUT_MOD,
        S_PUT_PUSH,
        S_REFILL,
        S_RESULT
    } fsm_state_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } mod_stat_t;

endpackage

/* rtl/core/fcpa_stack_ram.sv */
// Free address stack storage: one write port, one registered read port.
module fcpa_stack_ram #(
    parameter int DEPTH = fcpa_pkg::MAX_CHUNKS_DEF,
    parameter int AW    = 6
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [fcpa_pkg::ADDR_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [fcpa_pkg::ADDR_W-1:0] rdata
);
    import fcpa_pkg::*;

    logic [ADDR_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/fcpa_mod_unit.sv */
// Restoring remainder unit: one quotient bit per cycle, reports a zero remainder.
module fcpa_mod_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fcpa_pkg::OFF_W-1:0]   dividend,
    input  logic [fcpa_pkg::BYTES_W-1:0] divisor,
    output fcpa_pkg::mod_stat_t         stat
);
    import fcpa_pkg::*;

    localparam int STEP_W = $clog2(QUO_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [OFF_W-1:0]  rem_reg, rem_next;
    logic [BYTES_W-1:0] dvs_reg, dvs_next;
    logic [OFF_W-1:0]  shifted;

    assign shifted = OFF_W'(dvs_reg) << step_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = LAST_STEP;
            rem_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= shifted)
            begin
                rem_next = rem_reg - shifted;
            end
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign stat.done     = done_reg;
    assign stat.rem_zero = (rem_reg == '0);

endmodule

/* rtl/core/fixed_chunk_pool_allocator_unit.sv */
// Top level of the fixed-size chunk pool allocator with its free address stack.
//
// One item is worked on at a time and each gives one result. A get reads the
// stack memory, whose read port is registered; an empty stack skips the read.
// A put computes the offset, does a range check, then, unless the chunk size
// is zero, a seven-step remainder unit tests that the address starts a chunk,
// then the push. A refill makes one stack write per chunk of the effective
// chunk count. The stack memory needs no clearing after reset.
// A finished result waits in an output register, so the next item is taken
// while it waits. Configuration is read live by every item.
module fixed_chunk_pool_allocator_unit #(
    parameter int MAX_CHUNKS = fcpa_pkg::MAX_CHUNKS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [fcpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fcpa_pkg::ADDR_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fcpa_pkg::ACTION_W-1:0]  action,
    input  logic [fcpa_pkg::ADDR_W-1:0]    chunk_address,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fcpa_pkg::ADDR_W-1:0]    given_address,
    output logic [fcpa_pkg::STATUS_W-1:0]  status
);
    import fcpa_pkg::*;

    localparam int TOP_W = $clog2(MAX_CHUNKS + 1);
    localparam int AW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W = (TOP_W > COUNT_W) ? TOP_W : COUNT_W;
    localparam logic [TOP_W-1:0] MAX_TOP = TOP_W'(MAX_CHUNKS);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHUNKS);

    fsm_state_t state_reg, state_next;

    logic [ADDR_W-1:0]  pool_base_reg;
    logic [BYTES_W-1:0] chunk_bytes_reg;
    logic [COUNT_W-1:0] chunk_count_reg;

    logic [TOP_W-1:0]   top_reg, top_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic               below_reg, below_next;
    logic [ADDR_W-1:0]  off_reg, off_next;
    logic [OFF_W-1:0]   last_reg, last_next;
    logic [TOP_W-1:0]   idx_reg, idx_next;
    logic [ADDR_W-1:0]  fill_addr_reg, fill_addr_next;
    logic [TOP_W-1:0]   nfill_reg, nfill_next;
    logic [ADDR_W-1:0]  res_given_reg, res_given_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  out_given_reg, out_given_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic               accept_in;
    logic               out_free;
    logic [CNT_W-1:0]   live_cnt;
    logic [COUNT_W-1:0] live7;
    logic [TOP_W-1:0]   top_m1;
    logic               outside;
    logic [OFF_W-1:0]   last_prod;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ADDR_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ADDR_W-1:0]  ram_rdata;
    logic               div_start;
    mod_stat_t          mod_stat;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept_in = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign live_cnt  = (CNT_W'(chunk_count_reg) > MAX_CNT) ? MAX_CNT : CNT_W'(chunk_count_reg);
    assign live7     = live_cnt[COUNT_W-1:0];
    assign top_m1    = top_reg - 1'b1;
    assign outside   = below_reg || (off_reg > ADDR_W'(last_reg));
    assign last_prod = OFF_W'(chunk_bytes_reg) * OFF_W'(live7 - 1'b1);

    fcpa_stack_ram #(
        .DEPTH (MAX_CHUNKS),
        .AW    (AW)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fcpa_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (off_reg[OFF_W-1:0]),
        .divisor  (chunk_bytes_reg),
        .stat     (mod_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    case (action)
                        ACT_GET:    state_next = (top_reg == '0) ? S_RESULT : S_GET_WAIT;
                        ACT_PUT:    state_next = S_PUT_PREP;
                        ACT_REFILL: state_next = S_REFILL;
                        default:    state_next = S_RESULT;
                    endcase
                end
            end
            S_GET_WAIT:  state_next = S_RESULT;
            S_PUT_PREP:  state_next = S_PUT_RANGE;
            S_PUT_RANGE:
            begin
                if (outside)
                begin
                    state_next = S_RESULT;
                end
                else if (chunk_bytes_reg == '0)
                begin
                    state_next = S_PUT_PUSH;
                end
                else
                begin
                    state_next = S_PUT_MOD;
                end
            end
            S_PUT_MOD:
            begin
                if (mod_stat.done)
                begin
                    state_next = mod_stat.rem_zero ? S_PUT_PUSH : S_RESULT;
                end
            end
            S_PUT_PUSH:  state_next = S_RESULT;
            S_REFILL:    state_next = (idx_reg == nfill_reg) ? S_RESULT : S_REFILL;
            S_RESULT:    state_next = out_free ? S_IDLE : S_RESULT;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        top_next        = top_reg;
        addr_next       = addr_reg;
        below_next      = below_reg;
        off_next        = off_reg;
        last_next       = last_reg;
        idx_next        = idx_reg;
        fill_addr_next  = fill_addr_reg;
        nfill_next      = nfill_reg;
        res_given_next  = res_given_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_given_next  = out_given_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = top_reg[AW-1:0];
        ram_wdata       = addr_reg;
        ram_re          = 1'b0;
        ram_raddr       = top_m1[AW-1:0];
        div_start       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    addr_next       = chunk_address;
                    res_given_next  = '0;
                    res_status_next = ST_OK;
                    idx_next        = '0;
                    fill_addr_next  = pool_base_reg;
                    nfill_next      = live_cnt[TOP_W-1:0];
                    if (action == ACT_GET)
                    begin
                        if (top_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            ram_re   = 1'b1;
                            top_next = top_m1;
                        end
                    end
                end
            end
            S_GET_WAIT:
            begin
                res_given_next = ram_rdata;
            end
            S_PUT_PREP:
            begin
                below_next = (addr_reg < pool_base_reg) || (live_cnt == '0);
                off_next   = addr_reg - pool_base_reg;
                last_next  = last_prod;
            end
            S_PUT_RANGE:
            begin
                if (outside)
                begin
                    res_status_next = ST_OUTSIDE;
                end
                else if (chunk_bytes_reg != '0)
                begin
                    div_start = 1'b1;
                end
            end
            S_PUT_MOD:
            begin
                if (mod_stat.done && !mod_stat.rem_zero)
                begin
                    res_status_next = ST_NOT_START;
                end
            end
            S_PUT_PUSH:
            begin
                if (top_reg >= MAX_TOP)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    ram_we   = 1'b1;
                    top_next = top_reg + 1'b1;
                end
            end
            S_REFILL:
            begin
                if (idx_reg != nfill_reg)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = idx_reg[AW-1:0];
                    ram_wdata      = fill_addr_reg;
                    idx_next       = idx_reg + 1'b1;
                    fill_addr_next = fill_addr_reg + ADDR_W'(chunk_bytes_reg);
                end
                else
                begin
                    top_next = nfill_reg;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_given_next  = res_given_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            top_reg         <= '0;
            out_valid_reg   <= 1'b0;
            pool_base_reg   <= POOL_BASE_RST;
            chunk_bytes_reg <= CHUNK_BYTES_RST;
            chunk_count_reg <= CHUNK_COUNT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_POOL_BASE:   pool_base_reg   <= cfg_data;
                    CFG_CHUNK_BYTES: chunk_bytes_reg <= cfg_data[BYTES_W-1:0];
                    CFG_CHUNK_COUNT: chunk_count_reg <= cfg_data[COUNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        below_reg      <= below_next;
        off_reg        <= off_next;
        last_reg       <= last_next;
        idx_reg        <= idx_next;
        fill_addr_reg  <= fill_addr_next;
        nfill_reg      <= nfill_next;
        res_given_reg  <= res_given_next;
        res_status_reg <= res_status_next;
        out_given_reg  <= out_given_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid     = out_valid_reg;
    assign given_address = out_given_reg;
    assign status        = out_status_reg;

`ifndef SYNTHESIS
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= MAX_TOP)
        else $error("stack top beyond depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == S_PUT_PUSH) |-> (top_reg < MAX_TOP))
        else $error("push into full stack");

    a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
        mod_stat.done |-> (state_reg == S_PUT_MOD))
        else $error("remainder done outside put check");

    a_given_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (given_address == '0))
        else $error("address given with failing status");
`endif

endmodule
